### design/shelf_atlas_packer_defines.svh
// Assertion macros shared by the shelf atlas packer RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef SHELF_ATLAS_PACKER_DEFINES_SVH
`define SHELF_ATLAS_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
// check a condition at every clock edge outside reset
`define SAP_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("shelf atlas packer check failed");
// check that a cause is followed by an effect on the next edge
`define SAP_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
		else $error("shelf atlas packer sequence check failed");
`else
`define SAP_ASSERT(label, clk, rst_n, expr)
`define SAP_ASSERT_NEXT(label, clk, rst_n, cause, effect)
`endif

`endif

### design/sap_pkg.sv
// Types and codes of the shelf atlas packer.
// Used by the page evaluation unit and the top level; no dependencies.
package sap_pkg;

	localparam logic [1:0] STATUS_PLACED  = 2'd0;
	localparam logic [1:0] STATUS_BAD     = 2'd1;
	localparam logic [1:0] STATUS_NO_PAGE = 2'd2;

	localparam logic [9:0]  CURSOR_MAX = 10'd1023;
	localparam logic [10:0] TOP_MAX    = 11'd2047;

	// per-page shelf state
	typedef struct packed {
		logic [9:0]  cursor_x;
		logic [10:0] top_y;
		logic [9:0]  row_height;
	} page_state_t;

	// item and spacing handed to the evaluation unit
	typedef struct packed {
		logic [9:0] width;
		logic [9:0] height;
		logic [3:0] spacing;
	} rect_req_t;

	// verdict for one page
	typedef struct packed {
		logic        fits;
		page_state_t next_state;
		logic [8:0]  pos_x;
		logic [8:0]  pos_y;
	} page_eval_t;

endpackage

### design/shelf_atlas_packer.sv
// Shelf first-fit rectangle packer over a set of fixed-size atlas pages.
// Command channel: drive rect_width/rect_height with start; the item is taken
// at an edge where start is high and busy is low. busy stays high while the
// open pages are scanned.
// Result channel: done is high for exactly one cycle with status, page_index,
// pos_x, pos_y and opened_page; the receiver must take it then.
// Timing: a zero or oversized rectangle is answered in the cycle after
// acceptance without raising busy. Otherwise the sequencer examines one open
// page per cycle in the shared evaluation unit, and a new page is opened in
// the ST_OPEN state, after the scan or at once when no page is open yet; at
// most MAX_PAGES pages are open, 16 at the default. done is high in the first
// cycle with busy low, and a new item may be accepted in that same cycle.
// Configuration: cfg_we writes cfg_wdata into the item spacing register;
// write only while idle.
// Reset: all pages are closed and item spacing returns to 1; no clearing
// pass is needed because page state is written when a page opens.
`include "shelf_atlas_packer_defines.svh"

module shelf_atlas_packer import sap_pkg::*; #(
	parameter int PAGE_WIDTH  = 512,
	parameter int PAGE_HEIGHT = 512,
	parameter int MAX_PAGES   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       start,
	output logic       busy,
	input  logic [9:0] rect_width,
	input  logic [9:0] rect_height,
	output logic       done,
	output logic [1:0] status,
	output logic [3:0] page_index,
	output logic [8:0] pos_x,
	output logic [8:0] pos_y,
	output logic       opened_page
);

	localparam int PIDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OPEN
	} state_t;

	state_t            state_q;
	logic [3:0]        spacing_q;
	logic [CNT_W-1:0]  count_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [9:0]        width_q;
	logic [9:0]        height_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [3:0]        page_q;
	logic [8:0]        pos_x_q;
	logic [8:0]        pos_y_q;
	logic              opened_q;
	page_state_t       pages_q [MAX_PAGES];

	logic              accept;
	logic              bad_rect;
	logic              last_page;
	logic              full;
	logic [12:0]       open_sum;
	page_state_t       open_state;
	rect_req_t         req;
	page_eval_t        eval;

	assign accept    = start && (state_q == ST_IDLE);
	assign bad_rect  = (rect_width == '0) || (rect_height == '0) ||
		(13'(rect_width) > 13'(PAGE_WIDTH)) || (13'(rect_height) > 13'(PAGE_HEIGHT));
	assign last_page = (CNT_W'(pidx_q) + CNT_W'(1)) == count_q;
	assign full      = count_q == CNT_W'(MAX_PAGES);
	assign busy      = state_q != ST_IDLE;

	assign req.width   = width_q;
	assign req.height  = height_q;
	assign req.spacing = spacing_q;

	assign open_sum              = 13'(width_q) + 13'(spacing_q);
	assign open_state.cursor_x   = (open_sum > 13'(CURSOR_MAX)) ? CURSOR_MAX : open_sum[9:0];
	assign open_state.top_y      = '0;
	assign open_state.row_height = height_q;

	sap_page_unit #(
		.PAGE_WIDTH  (PAGE_WIDTH),
		.PAGE_HEIGHT (PAGE_HEIGHT)
	) u_unit (
		.cur (pages_q[pidx_q]),
		.req (req),
		.res (eval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			spacing_q <= 4'd1;
			count_q   <= '0;
			pidx_q    <= '0;
			width_q   <= '0;
			height_q  <= '0;
			done_q    <= 1'b0;
			status_q  <= STATUS_PLACED;
			page_q    <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			opened_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				spacing_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						width_q  <= rect_width;
						height_q <= rect_height;
						pidx_q   <= '0;
						if (bad_rect) begin
							done_q   <= 1'b1;
							status_q <= STATUS_BAD;
							page_q   <= '0;
							pos_x_q  <= '0;
							pos_y_q  <= '0;
							opened_q <= 1'b0;
						end else if (count_q == '0) begin
							state_q <= ST_OPEN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (eval.fits) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						status_q <= STATUS_PLACED;
						page_q   <= 4'(pidx_q);
						pos_x_q  <= eval.pos_x;
						pos_y_q  <= eval.pos_y;
						opened_q <= 1'b0;
					end else if (last_page) begin
						if (full) begin
							// drop the item; wraps made on the way stay
							state_q  <= ST_IDLE;
							done_q   <= 1'b1;
							status_q <= STATUS_NO_PAGE;
							page_q   <= '0;
							pos_x_q  <= '0;
							pos_y_q  <= '0;
							opened_q <= 1'b0;
						end else begin
							state_q <= ST_OPEN;
						end
					end else begin
						pidx_q <= pidx_q + PIDX_W'(1);
					end
				end
				ST_OPEN: begin
					state_q  <= ST_IDLE;
					count_q  <= count_q + CNT_W'(1);
					done_q   <= 1'b1;
					status_q <= STATUS_PLACED;
					page_q   <= 4'(count_q[PIDX_W-1:0]);
					pos_x_q  <= '0;
					pos_y_q  <= '0;
					opened_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// page state store, written back at the scanned page or the new page
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			pages_q[pidx_q] <= eval.next_state;
		end else if (state_q == ST_OPEN) begin
			pages_q[count_q[PIDX_W-1:0]] <= open_state;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign page_index  = page_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign opened_page = opened_q;

	`SAP_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(MAX_PAGES))
	`SAP_ASSERT(a_fail_fields_zero, clk, arst_n, !(done_q && status_q != STATUS_PLACED) || (page_q == '0 && pos_x_q == '0 && pos_y_q == '0 && !opened_q))
	`SAP_ASSERT(a_open_is_newest, clk, arst_n, !(done_q && opened_q) || (5'(count_q) == 5'(page_q) + 5'd1))
	`SAP_ASSERT_NEXT(a_accept_answers, clk, arst_n, accept, busy || done_q)
	`SAP_ASSERT(a_scan_in_range, clk, arst_n, state_q != ST_SCAN || (CNT_W'(pidx_q) < count_q))

endmodule

### design/sap_page_unit.sv
// Shared evaluation unit: wraps a page's shelf if needed and tests vertical room.
// Depends on sap_pkg.
module sap_page_unit import sap_pkg::*; #(
	parameter int PAGE_WIDTH  = 512,
	parameter int PAGE_HEIGHT = 512
) (
	input  page_state_t cur,
	input  rect_req_t   req,
	output page_eval_t  res
);

	localparam logic [12:0] PW = 13'(PAGE_WIDTH);
	localparam logic [12:0] PH = 13'(PAGE_HEIGHT);

	logic        wrap;
	logic [12:0] top_sum;
	logic [10:0] top_w;
	logic [9:0]  cur_w;
	logic [9:0]  rh_w;
	logic [12:0] cur_sum;
	logic [9:0]  cur_next;

	always_comb begin
		wrap    = (13'(cur.cursor_x) + 13'(req.width)) > PW;
		top_sum = 13'(cur.top_y) + 13'(cur.row_height) + 13'(req.spacing);
		// start a new shelf below the current row
		if (wrap) begin
			top_w = (top_sum > 13'(TOP_MAX)) ? TOP_MAX : top_sum[10:0];
			cur_w = '0;
			rh_w  = '0;
		end else begin
			top_w = cur.top_y;
			cur_w = cur.cursor_x;
			rh_w  = cur.row_height;
		end
		cur_sum  = 13'(cur_w) + 13'(req.width) + 13'(req.spacing);
		cur_next = (cur_sum > 13'(CURSOR_MAX)) ? CURSOR_MAX : cur_sum[9:0];

		res.fits  = (13'(top_w) + 13'(req.height)) <= PH;
		res.pos_x = cur_w[8:0];
		res.pos_y = top_w[8:0];
		if (res.fits) begin
			res.next_state.cursor_x   = cur_next;
			res.next_state.top_y      = top_w;
			res.next_state.row_height = (req.height > rh_w) ? req.height : rh_w;
		end else begin
			res.next_state.cursor_x   = cur_w;
			res.next_state.top_y      = top_w;
			res.next_state.row_height = rh_w;
		end
	end

endmodule

### tb/sv/sap_placement_checker.sv
// Placement checker for the shelf atlas packer: watches the command, result and
// spacing channels, predicts each placement and compares it with the block's answer.
// Depends on sap_pkg for the status codes and the per-page shelf state type.
`timescale 1ns / 100ps

module sap_placement_checker import sap_pkg::*; #(
	parameter int PAGE_WIDTH  = 512,
	parameter int PAGE_HEIGHT = 512,
	parameter int MAX_PAGES   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       start,
	input  logic       busy,
	input  logic [9:0] rect_width,
	input  logic [9:0] rect_height,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [3:0] page_index,
	input  logic [8:0] pos_x,
	input  logic [8:0] pos_y,
	input  logic       opened_page,
	output int         mismatches,
	output int         pending,
	output int         n_placed,
	output int         n_opened,
	output int         n_rejected,
	output int         n_full
);

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] page;
		logic [8:0] x;
		logic [8:0] y;
		logic       opened;
	} placement_t;

	page_state_t shelves [16];
	int          open_pages;
	logic [3:0]  spacing;
	placement_t  expected_placements [$];

	function automatic int clip(int v, int hi);
		return (v > hi) ? hi : v;
	endfunction

	// advance the shelf state for one rectangle and return where it lands
	function automatic placement_t predict_placement(logic [9:0] w, logic [9:0] h);
		int         wi;
		int         hi;
		int         s;
		int         n;
		int         x;
		int         y;
		placement_t res;
		wi  = w;
		hi  = h;
		s   = spacing;
		n   = (open_pages > MAX_PAGES) ? MAX_PAGES : open_pages;
		res = '0;
		if (wi == 0 || hi == 0 || wi > PAGE_WIDTH || hi > PAGE_HEIGHT) begin
			res.status = STATUS_BAD;
			return res;
		end
		for (int p = 0; p < n; p++) begin
			if (int'(shelves[p].cursor_x) + wi > PAGE_WIDTH) begin
				// wrap to a new shelf below the current row
				shelves[p].cursor_x   = '0;
				shelves[p].top_y      = 11'(clip(int'(shelves[p].top_y) +
					int'(shelves[p].row_height) + s, int'(TOP_MAX)));
				shelves[p].row_height = '0;
			end
			if (int'(shelves[p].top_y) + hi <= PAGE_HEIGHT) begin
				x = shelves[p].cursor_x;
				y = shelves[p].top_y;
				shelves[p].cursor_x = 10'(clip(x + wi + s, int'(CURSOR_MAX)));
				if (h > shelves[p].row_height)
					shelves[p].row_height = h;
				res.status = STATUS_PLACED;
				res.page   = 4'(p);
				res.x      = 9'(x);
				res.y      = 9'(y);
				return res;
			end
		end
		if (n >= MAX_PAGES) begin
			res.status = STATUS_NO_PAGE;
			return res;
		end
		shelves[n].cursor_x   = 10'(clip(wi + s, int'(CURSOR_MAX)));
		shelves[n].top_y      = '0;
		shelves[n].row_height = h;
		open_pages = n + 1;
		res.status = STATUS_PLACED;
		res.page   = 4'(n);
		res.opened = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t got;
		placement_t want;
		if (!arst_n) begin
			spacing    = 4'd1;
			open_pages = 0;
			for (int i = 0; i < 16; i++)
				shelves[i] = '0;
			expected_placements.delete();
			mismatches <= 0;
			pending    <= 0;
			n_placed   <= 0;
			n_opened   <= 0;
			n_rejected <= 0;
			n_full     <= 0;
		end else begin
			got = '{status, page_index, pos_x, pos_y, opened_page};
			if (done) begin
				if (expected_placements.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected: st=%0d pg=%0d x=%0d y=%0d op=%0d",
							$realtime, got.status, got.page, got.x, got.y, got.opened);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_placements.pop_front();
					if (got.status !== want.status || got.page !== want.page ||
						got.x !== want.x || got.y !== want.y || got.opened !== want.opened) begin
						if (mismatches < 10)
							$display("%0t: placement differs: exp st=%0d pg=%0d x=%0d y=%0d op=%0d, got st=%0d pg=%0d x=%0d y=%0d op=%0d",
								$realtime, want.status, want.page, want.x, want.y, want.opened,
								got.status, got.page, got.x, got.y, got.opened);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (start && !busy) begin
				want = predict_placement(rect_width, rect_height);
				expected_placements.push_back(want);
				case (want.status)
					STATUS_PLACED: begin
						n_placed <= n_placed + 1;
						if (want.opened)
							n_opened <= n_opened + 1;
					end
					STATUS_BAD:     n_rejected <= n_rejected + 1;
					default:        n_full <= n_full + 1;
				endcase
			end
			// spacing applies to items accepted after the write
			if (cfg_we)
				spacing = cfg_wdata;
			pending <= expected_placements.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// Top of the shelf atlas packer testbench: clock, reset, rectangle stimulus and
// spacing writes; sap_placement_checker predicts and compares the placements.
// Depends on sap_pkg, shelf_atlas_packer and sap_placement_checker.
`timescale 1ns / 100ps

module tb_top;

	localparam int PAGE_W      = 512;
	localparam int PAGE_H      = 512;
	localparam int PAGES       = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_we      = 1'b0;
	logic [3:0] cfg_wdata   = 4'd0;
	logic       start       = 1'b0;
	logic [9:0] rect_width  = 10'd0;
	logic [9:0] rect_height = 10'd0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [3:0] page_index;
	logic [8:0] pos_x;
	logic [8:0] pos_y;
	logic       opened_page;

	int mismatches;
	int pending;
	int n_placed;
	int n_opened;
	int n_rejected;
	int n_full;
	int items_sent = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	shelf_atlas_packer #(
		.PAGE_WIDTH (PAGE_W),
		.PAGE_HEIGHT(PAGE_H),
		.MAX_PAGES  (PAGES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.done       (done),
		.status     (status),
		.page_index (page_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.opened_page(opened_page)
	);

	sap_placement_checker #(
		.PAGE_WIDTH (PAGE_W),
		.PAGE_HEIGHT(PAGE_H),
		.MAX_PAGES  (PAGES)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.done       (done),
		.status     (status),
		.page_index (page_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.opened_page(opened_page),
		.mismatches (mismatches),
		.pending    (pending),
		.n_placed   (n_placed),
		.n_opened   (n_opened),
		.n_rejected (n_rejected),
		.n_full     (n_full)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d placements outstanding", cycle_count, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// present one rectangle and hold it until the block takes it
	task automatic send_rect(input logic [9:0] w, input logic [9:0] h);
		if (!quiet && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		rect_width  <= w;
		rect_height <= h;
		start       <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_spacing(input logic [3:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly small rectangles so pages fill slowly; some extremes and noise
	task automatic rand_rect(output logic [9:0] w, output logic [9:0] h);
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			w = 10'($urandom_range(1, 48));
			h = 10'($urandom_range(1, 48));
		end else if (r < 72) begin
			w = 10'($urandom_range(1, PAGE_W));
			h = 10'($urandom_range(1, 32));
		end else if (r < 76) begin
			w = 10'($urandom_range(1, 32));
			h = 10'($urandom_range(1, PAGE_H / 2));
		end else if (r < 84) begin
			case ($urandom_range(2))
				0:       w = 10'd1;
				1:       w = 10'(PAGE_W - 1);
				default: w = 10'(PAGE_W);
			endcase
			h = 10'($urandom_range(1, 16));
		end else if (r < 95) begin
			w = 10'($urandom);
			h = 10'($urandom);
		end else begin
			w = $urandom_range(1) ? 10'd0 : 10'($urandom);
			h = (w == 0) ? 10'($urandom) : 10'd0;
		end
	endtask

	initial begin
		logic [9:0] w;
		logic [9:0] h;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, full-page and edge-sized rectangles at reset spacing
		send_rect(10'd0, 10'd0);
		send_rect(10'd0, 10'd7);
		send_rect(10'd7, 10'd0);
		send_rect(10'(PAGE_W + 1), 10'd8);
		send_rect(10'd8, 10'(PAGE_H + 1));
		send_rect(10'd1023, 10'd1023);
		send_rect(10'd1023, 10'd1);
		send_rect(10'd1, 10'd1023);
		send_rect(10'(PAGE_W), 10'(PAGE_H));
		send_rect(10'd1, 10'd1);
		send_rect(10'(PAGE_W), 10'd1);
		send_rect(10'd1, 10'(PAGE_H));
		send_rect(10'(PAGE_W - 1), 10'd3);
		send_rect(10'd1, 10'd3);
		send_rect(10'd1, 10'd3);
		send_rect(10'd10, 10'd10);
		send_rect(10'd10, 10'd20);
		send_rect(10'd600, 10'd600);

		write_spacing(4'd0);
		for (int i = 0; i < 200; i++) begin
			rand_rect(w, h);
			send_rect(w, h);
			// let the block run dry once mid-phase
			if (i == 100)
				drain();
		end

		write_spacing(4'd15);
		for (int i = 0; i < 200; i++) begin
			quiet = (i >= 40 && i < 140);
			rand_rect(w, h);
			send_rect(w, h);
		end
		quiet = 1'b0;

		write_spacing(4'($urandom_range(2, 14)));
		for (int i = 0; i < 200; i++) begin
			rand_rect(w, h);
			send_rect(w, h);
		end

		write_spacing(4'd1);
		for (int i = 0; i < 180; i++) begin
			rand_rect(w, h);
			send_rect(w, h);
		end

		// use up the remaining pages, then keep trying into leftover gaps
		write_spacing(4'($urandom));
		for (int i = 0; i < 70; i++) begin
			if ($urandom_range(3) == 0) begin
				rand_rect(w, h);
			end else begin
				w = 10'($urandom_range(128, PAGE_W));
				h = 10'($urandom_range(128, PAGE_H));
			end
			send_rect(w, h);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d rectangles over spacings 1, 0, 15 and random: %0d placed, %0d opened a page,",
			items_sent, n_placed, n_opened);
		$display("%0d rejected as zero or oversized, %0d found no page left", n_rejected, n_full);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/sap_pkg.sv
design/sap_page_unit.sv
design/shelf_atlas_packer.sv
tb/sv/sap_placement_checker.sv
tb/sv/tb_top.sv
